[rtl/sha256_pkg.sv]
package sha256_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } sha_state_e;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlockLen = 16;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned Digests  = 8;

  typedef logic [WordW-1:0] word_t;

  localparam logic [2:0] FullBytes = 3'd4;
  localparam word_t PadOne = 32'h8000_0000;

  // Initial chaining values H0..H7
  localparam word_t InitH [Digests] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Keep the leading bytes of a short final word and append the 0x80 marker
  function automatic word_t pad_partial(word_t data, logic [2:0] nbytes);
    word_t w;
    w = '0;
    unique case (nbytes)
      3'd0:    w = PadOne;
      3'd1:    w = {data[31:24], 24'h80_0000};
      3'd2:    w = {data[31:16], 16'h8000};
      3'd3:    w = {data[31:8], 8'h80};
      default: w = data;
    endcase
    return w;
  endfunction

endpackage

[rtl/sha256_hash_core.sv]
// SHA-256 hash core, streaming one big-endian 32-bit message word per request.
//
// Input channel: data_word_i, valid_bytes_i and last_i travel with in_valid_i;
// a request is taken at a clock edge with in_valid_i high and in_stall_o low.
// valid_bytes_i counts only on the last word (values above four mean four).
// Output channel: eight requests per message, digest_word_o with word_index_o
// 0..7, digest_last_o on the eighth; each is taken when out_stall_i is low.
//
// The sixteenth word of a block starts the compression: 64 rounds at one
// round per cycle through a single round unit, then a fold into the chaining
// values in ST_FINAL. On the last word the core generates the padding and
// length words itself at one per cycle, runs one or two further blocks, then
// offers the digest words, one per cycle while the receiver does not stall.
// A stalled digest word holds until taken. Input stalls through every
// compression and from the last word until the eighth digest word leaves.
// When the eighth digest word is taken, the chaining values and length return
// to their initial values; reset (rst_ni low) does the same at once.
module sha256_hash_core
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  sha_state_e  state_q, state_d;
  word_t       chain_q [Digests];
  word_t       chain_d [Digests];
  word_t       vars_q [Digests];
  word_t       vars_d [Digests];
  word_t       win_q [BlockLen];
  word_t       win_d [BlockLen];
  logic [63:0] bit_len_q, bit_len_d;
  logic [3:0]  pos_q, pos_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        pad_q, pad_d;
  logic        need_one_q, need_one_d;
  logic        hi_done_q, hi_done_d;

  logic        in_take;
  logic        out_take;
  logic        push_en;
  word_t       push_word;
  logic [2:0]  nbytes;
  word_t       t1, t2, next_w;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign nbytes   = (valid_bytes_i > FullBytes) ? FullBytes : valid_bytes_i;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign digest_last_o = (idx_q == 3'(Digests - 1));

  // Round unit fed from the window head, and schedule expansion over the window
  always_comb begin
    t1 = vars_q[7] + big_sig1(vars_q[4])
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
       + RoundK[rnd_q] + win_q[0];
    t2 = big_sig0(vars_q[0])
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
    next_w = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d    = state_q;
    chain_d    = chain_q;
    vars_d     = vars_q;
    win_d      = win_q;
    bit_len_d  = bit_len_q;
    pos_d      = pos_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    pad_d      = pad_q;
    need_one_d = need_one_q;
    hi_done_d  = hi_done_q;
    push_en    = 1'b0;
    push_word  = data_word_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          push_en = 1'b1;
          if (last_i) begin
            bit_len_d  = bit_len_q + 64'({nbytes, 3'b000});
            pad_d      = 1'b1;
            need_one_d = (nbytes == FullBytes);
            hi_done_d  = 1'b0;
            push_word  = pad_partial(data_word_i, nbytes);
            state_d    = ST_PAD;
          end else begin
            bit_len_d = bit_len_q + 64'(WordW);
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        priority if (need_one_q) begin
          push_word  = PadOne;
          need_one_d = 1'b0;
        end else if (pos_q == 4'(BlockLen - 2)) begin
          push_word = bit_len_q[63:32];
          hi_done_d = 1'b1;
        end else if (pos_q == 4'(BlockLen - 1) && hi_done_q) begin
          push_word = bit_len_q[31:0];
        end else begin
          push_word = '0;
        end
      end
      ST_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          vars_d[i] = vars_q[i-1];
        end
        vars_d[4] = vars_q[3] + t1;
        vars_d[0] = t1 + t2;
        for (int i = 0; i < BlockLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[BlockLen-1] = next_w;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < Digests; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        priority if (pad_q && hi_done_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_take) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(Digests - 1)) begin
            chain_d   = InitH;
            bit_len_d = '0;
            pad_d     = 1'b0;
            hi_done_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Shift a word into the window; a full window starts the rounds
    if (push_en) begin
      for (int i = 0; i < BlockLen - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[BlockLen-1] = push_word;
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'(BlockLen - 1)) begin
        vars_d  = chain_q;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
    end
  end

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chain_q    <= InitH;
      bit_len_q  <= '0;
      pos_q      <= '0;
      rnd_q      <= '0;
      idx_q      <= '0;
      pad_q      <= 1'b0;
      need_one_q <= 1'b0;
      hi_done_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      chain_q    <= chain_d;
      bit_len_q  <= bit_len_d;
      pos_q      <= pos_d;
      rnd_q      <= rnd_d;
      idx_q      <= idx_d;
      pad_q      <= pad_d;
      need_one_q <= need_one_d;
      hi_done_q  <= hi_done_d;
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
  end

  // A compression only runs on a full window
  a_round_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (pos_q == '0))
    else $error("compression running on a partial block");

  // Rounds always start from round zero
  a_round_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && $past(state_q) != ST_ROUND) |-> (rnd_q == '0))
    else $error("round counter not cleared at block start");

  // The final digest word clears the message state
  a_msg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && idx_q == 3'(Digests - 1)) |=>
      (bit_len_q == '0 && pos_q == '0 && !pad_q && state_q == ST_IDLE))
    else $error("message state not cleared after digest");

  // Padding never runs without a last word having been taken
  a_pad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD || state_q == ST_OUT) |-> pad_q)
    else $error("padding state without a pending last word");

endmodule
